FILE: hw/rtl/optical_density_regulator_logger_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the optical density regulator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef OPTICAL_DENSITY_REGULATOR_LOGGER_ASSERT_SVH
`define OPTICAL_DENSITY_REGULATOR_LOGGER_ASSERT_SVH
`ifndef SYNTHESIS
// check held while reset is low
`define ODRL_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// check held on every edge, reset included
`define ODRL_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define ODRL_ASSERT(lbl, ck, rs, prop, msg)
`define ODRL_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif
`endif

FILE: hw/rtl/odrl_pkg.sv
// ----------------------------------------------------------------------------
// odrl_pkg
// Types and fixed constants shared by the optical density regulator files.
// ----------------------------------------------------------------------------
package odrl_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd4;

  // register widths and reset values
  localparam int TARGET_W = 13;
  localparam int REF_W    = 14;
  localparam int SLOPE_W  = 16;
  localparam int WINLEN_W = 11;
  localparam int INTV_W   = 8;

  localparam logic [TARGET_W-1:0] TARGET_RST = 13'd410;
  localparam logic [REF_W-1:0]    REF_RST    = 14'd12126;
  localparam logic [SLOPE_W-1:0]  SLOPE_RST  = 16'd35598;
  localparam logic [WINLEN_W-1:0] WINLEN_RST = 11'd1000;
  localparam logic [INTV_W-1:0]   INTV_RST   = 8'd5;

  // window: at most 2**WIN_LOG samples
  localparam int WIN_LOG = 10;
  localparam logic [WINLEN_W-1:0] WIN_MAX = 11'd1024;
  // reference level carries 4 fraction bits
  localparam int REF_FRAC = 4;

  // digit-serial multiplier
  localparam int MUL_W      = 32;
  localparam int DIGIT_W    = 4;
  localparam int MUL_DIGITS = MUL_W / DIGIT_W;
  localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);

  // log2 in Q20: exponent plus squaring fraction
  localparam int EXP_W   = 5;
  localparam int FRAC_W  = 20;
  localparam int LOG_W   = EXP_W + FRAC_W;
  localparam int ROUNDS  = FRAC_W;
  localparam int ROUND_W = 5;
  localparam logic [EXP_W-1:0] EXP_TOP = 5'd31;

  // ln2 in Q30
  localparam logic [MUL_W-1:0] LN2_Q30 = 32'd744261118;
  localparam int LN2_FRAC = 30;

  // density: Q20 * Q16 rounded to nearest Q10
  localparam int DQ_SHIFT = 26;
  localparam int DQ_W     = 16;
  localparam int DENS_W   = 14;
  localparam int DENS_HI_LIM = 8191;
  localparam int DENS_LO_LIM = 256;
  localparam logic signed [DENS_W-1:0] DENS_MAX = 14'sd8191;
  localparam logic signed [DENS_W-1:0] DENS_MIN = -14'sd256;

  // log byte: trunc(density * 100 / 1024), clamped
  localparam int PCT_SCALE = 100;
  localparam int PCT_W     = 20;
  localparam int PCT_SHIFT = 10;
  localparam int BYTE_W    = 8;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

  // item kinds on the input side
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // requests to the log ring
  typedef struct packed {
    logic wr;
    logic rd;
  } odrl_ring_req_t;

endpackage

FILE: hw/rtl/optical_density_regulator_logger.sv
// ----------------------------------------------------------------------------
// optical_density_regulator_logger
// Sums photodiode samples over a window, turns the average into optical
// density ln(ref/avg)*inverse_slope, drives the pump and logs every Nth
// measurement into a byte ring that can be read back by age.
// ----------------------------------------------------------------------------
//  channel  side    payload
//  s_*      in      tuser: mode; tdata: sample, read_index
//  m_*      out     tuser: is_readback; tdata: density, pump_on, logged,
//                   log_byte, entry_value, entries_used
//  APB      cfg     five registers at byte addresses 0,4,8,12,16
//
//  A sample that does not close its window is added while the input stays
//  ready. A log read goes through S_READ and then waits for the output
//  register. A closing sample with a nonzero sum makes 43 passes through the
//  shared 4-bit-per-cycle multiplier (20 squarings per log2) plus the
//  normalize shifts. Reset is synchronous; the log needs no clearing pass.
//  The input stalls while a result waits in the output register.
// ----------------------------------------------------------------------------
`include "optical_density_regulator_logger_assert.svh"

module optical_density_regulator_logger #(
  parameter int LOG_DEPTH   = 512,
  parameter int SAMPLE_BITS = 10
) (
  input  logic clk,
  input  logic rst,
  // input items
  input  logic s_tvalid,
  output logic s_tready,
  // tdata: sample, read_index (from bit 0 up)
  input  logic [(((SAMPLE_BITS + $clog2(LOG_DEPTH)) + 7) / 8) * 8 - 1:0] s_tdata,
  // tuser: mode
  input  logic s_tuser,
  // result items
  output logic m_tvalid,
  input  logic m_tready,
  // tdata: density, pump_on, logged, log_byte, entry_value, entries_used
  output logic [((odrl_pkg::DENS_W + 2 + 2 * odrl_pkg::BYTE_W + $clog2(LOG_DEPTH + 1)
                  + 7) / 8) * 8 - 1:0] m_tdata,
  // tuser: is_readback
  output logic m_tuser,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [odrl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [odrl_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [odrl_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import odrl_pkg::*;

  localparam int IDX_W  = $clog2(LOG_DEPTH);
  localparam int FILL_W = $clog2(LOG_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + WIN_LOG;
  localparam int IN_W   = SAMPLE_BITS + IDX_W;
  localparam int OUT_W  = DENS_W + 2 + 2 * BYTE_W + FILL_W;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_REFWIN = 9'b000000010,
    S_NORM   = 9'b000000100,
    S_SQUARE = 9'b000001000,
    S_LN     = 9'b000010000,
    S_SLOPE  = 9'b000100000,
    S_DONE   = 9'b001000000,
    S_EMIT   = 9'b010000000,
    S_READ   = 9'b100000000
  } state_t;

  // configuration registers
  logic [TARGET_W-1:0] target_density;
  logic [REF_W-1:0]    reference_level;
  logic [SLOPE_W-1:0]  inverse_slope;
  logic [WINLEN_W-1:0] window_length;
  logic [INTV_W-1:0]   log_interval;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;

  // control state
  state_t              state;
  logic [SUM_W-1:0]    sample_sum;
  logic [WINLEN_W-1:0] sample_count;
  logic [INTV_W-1:0]   measure_count;
  logic                pump_state;
  logic                mul_go;

  // work registers
  logic [SUM_W-1:0]         bsum;
  logic [MUL_W-1:0]         op_a;
  logic [MUL_W-1:0]         op_b;
  logic [MUL_W-1:0]         m_val;
  logic [EXP_W-1:0]         expo;
  logic [FRAC_W-1:0]        frac;
  logic [ROUND_W-1:0]       round;
  logic                     which_b;
  logic [LOG_W-1:0]         la;
  logic                     neg_r;
  logic signed [DENS_W-1:0] dens;
  logic [BYTE_W-1:0]        lb_r;
  logic                     logged_r;

  // input fields
  logic [SAMPLE_BITS-1:0] sample;
  logic [IDX_W-1:0]       read_index;
  logic                   accept;

  // sample window
  logic [SUM_W-1:0]    sum_add;
  logic [WINLEN_W-1:0] cnt_add;
  logic [WINLEN_W-1:0] win_eff;
  logic [REF_W-1:0]    ref_eff;
  logic                win_last;

  // multiplier
  logic                 mul_done;
  logic [MUL_W-1:0]     mul_hi;
  logic [MUL_W-1:0]     mul_lo;
  logic [2*MUL_W-1:0]   prod;
  logic [MUL_W:0]       sq;
  logic [MUL_W-1:0]     m_sq;
  logic [FRAC_W-1:0]    frac_next;
  logic [LOG_W-1:0]     log_val;
  logic                 neg;
  logic [LOG_W-1:0]     mag;
  logic [LOG_W-1:0]     lnq;
  logic [DQ_W:0]        rnd;
  logic [DQ_W-1:0]      dq;
  logic signed [DENS_W-1:0] dens_sat;

  // measurement wrap-up
  logic                 pump_now;
  logic [PCT_W-1:0]     prod100;
  logic [PCT_W-PCT_SHIFT-1:0] pct;
  logic [BYTE_W-1:0]    lb_now;
  logic [INTV_W-1:0]    cnt1;
  logic [INTV_W-1:0]    intv;
  logic                 log_hit;

  // log ring
  odrl_ring_req_t       ring_req;
  logic [BYTE_W-1:0]    rd_data;
  logic [FILL_W-1:0]    fill;

  // output register
  logic                 out_free;
  logic                 load_meas;
  logic                 load_rd;
  logic [OUT_W-1:0]     out_word;

  // configuration write and read
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_density  <= TARGET_RST;
      reference_level <= REF_RST;
      inverse_slope   <= SLOPE_RST;
      window_length   <= WINLEN_RST;
      log_interval    <= INTV_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TARGET:    target_density  <= pwdata[TARGET_W-1:0];
        REG_REFERENCE: reference_level <= pwdata[REF_W-1:0];
        REG_SLOPE:     inverse_slope   <= pwdata[SLOPE_W-1:0];
        REG_WINDOW:    window_length   <= pwdata[WINLEN_W-1:0];
        REG_INTERVAL:  log_interval    <= pwdata[INTV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TARGET:    prdata = CFG_DATA_W'(target_density);
      REG_REFERENCE: prdata = CFG_DATA_W'(reference_level);
      REG_SLOPE:     prdata = CFG_DATA_W'(inverse_slope);
      REG_WINDOW:    prdata = CFG_DATA_W'(window_length);
      REG_INTERVAL:  prdata = CFG_DATA_W'(log_interval);
      default:       prdata = '0;
    endcase
  end

  // input handshake and window accumulation
  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign sample     = s_tdata[SAMPLE_BITS-1:0];
  assign read_index = s_tdata[IN_W-1:SAMPLE_BITS];

  always_comb begin
    sum_add = sample_sum + SUM_W'(sample);
    cnt_add = sample_count + 1'b1;
    if (window_length == '0) begin
      win_eff = WINLEN_W'(1);
    end else if (window_length > WIN_MAX) begin
      win_eff = WIN_MAX;
    end else begin
      win_eff = window_length;
    end
    ref_eff  = (reference_level == '0) ? REF_W'(1) : reference_level;
    win_last = (cnt_add >= win_eff);
  end

  // squaring step, log difference, ln and slope scaling
  always_comb begin
    prod      = {mul_hi, mul_lo};
    sq        = {mul_hi, mul_lo[MUL_W-1]};
    m_sq      = sq[MUL_W] ? sq[MUL_W:1] : sq[MUL_W-1:0];
    frac_next = {frac[FRAC_W-2:0], sq[MUL_W]};
    log_val   = {expo, frac_next};
    neg       = (log_val > la);
    mag       = neg ? (log_val - la) : (la - log_val);
    lnq       = prod[LN2_FRAC +: LOG_W];
    rnd       = {1'b0, prod[DQ_SHIFT-1 +: DQ_W]} + (DQ_W+1)'(1);
    dq        = rnd[DQ_W:1];
    if (neg_r) begin
      if (dq > DQ_W'(DENS_LO_LIM)) begin
        dens_sat = DENS_MIN;
      end else begin
        dens_sat = -DENS_W'(dq);
      end
    end else begin
      if (dq > DQ_W'(DENS_HI_LIM)) begin
        dens_sat = DENS_MAX;
      end else begin
        dens_sat = DENS_W'(dq);
      end
    end
  end

  // pump decision, log byte, log interval
  always_comb begin
    pump_now = (dens > $signed({1'b0, target_density}));
    prod100  = PCT_W'(dens[DENS_W-2:0]) * PCT_W'(PCT_SCALE);
    pct      = prod100[PCT_W-1:PCT_SHIFT];
    if (dens > 0) begin
      lb_now = (pct > (PCT_W-PCT_SHIFT)'(BYTE_MAX)) ? BYTE_MAX : pct[BYTE_W-1:0];
    end else begin
      lb_now = '0;
    end
    cnt1    = measure_count + 1'b1;
    intv    = (log_interval == '0) ? INTV_W'(1) : log_interval;
    log_hit = (cnt1 >= intv);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sample_sum    <= '0;
      sample_count  <= '0;
      measure_count <= '0;
      pump_state    <= 1'b0;
      mul_go        <= 1'b0;
    end else begin
      mul_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser == MODE_READ) begin
              state <= S_READ;
            end else if (win_last) begin
              sample_sum   <= '0;
              sample_count <= '0;
              if (sum_add == '0) begin
                state <= S_DONE;
              end else begin
                mul_go <= 1'b1;
                state  <= S_REFWIN;
              end
            end else begin
              sample_sum   <= sum_add;
              sample_count <= cnt_add;
            end
          end
        end
        S_REFWIN: begin
          if (mul_done) begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (m_val[MUL_W-1]) begin
            mul_go <= 1'b1;
            state  <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          if (mul_done) begin
            if (round == ROUND_W'(ROUNDS - 1)) begin
              if (!which_b) begin
                state <= S_NORM;
              end else begin
                mul_go <= 1'b1;
                state  <= S_LN;
              end
            end else begin
              mul_go <= 1'b1;
            end
          end
        end
        S_LN: begin
          if (mul_done) begin
            mul_go <= 1'b1;
            state  <= S_SLOPE;
          end
        end
        S_SLOPE: begin
          if (mul_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          pump_state    <= pump_now;
          measure_count <= log_hit ? '0 : cnt1;
          state         <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // work registers of the density calculation
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept && (s_tuser == MODE_SAMPLE) && win_last) begin
          bsum <= sum_add;
          dens <= DENS_MAX;
          op_a <= MUL_W'(ref_eff);
          op_b <= MUL_W'(win_eff);
        end
      end
      S_REFWIN: begin
        if (mul_done) begin
          m_val   <= mul_lo;
          expo    <= EXP_TOP;
          which_b <= 1'b0;
        end
      end
      S_NORM: begin
        if (m_val[MUL_W-1]) begin
          op_a  <= m_val;
          op_b  <= m_val;
          round <= '0;
          frac  <= '0;
        end else begin
          m_val <= m_val << 1;
          expo  <= expo - 1'b1;
        end
      end
      S_SQUARE: begin
        if (mul_done) begin
          frac  <= frac_next;
          m_val <= m_sq;
          if (round == ROUND_W'(ROUNDS - 1)) begin
            if (!which_b) begin
              la      <= log_val;
              m_val   <= MUL_W'(bsum) << REF_FRAC;
              expo    <= EXP_TOP;
              which_b <= 1'b1;
            end else begin
              neg_r <= neg;
              op_a  <= LN2_Q30;
              op_b  <= MUL_W'(mag);
            end
          end else begin
            round <= round + 1'b1;
            op_a  <= m_sq;
            op_b  <= m_sq;
          end
        end
      end
      S_LN: begin
        if (mul_done) begin
          op_a <= MUL_W'(inverse_slope);
          op_b <= MUL_W'(lnq);
        end
      end
      S_SLOPE: begin
        if (mul_done) begin
          dens <= dens_sat;
        end
      end
      S_DONE: begin
        lb_r     <= lb_now;
        logged_r <= log_hit;
      end
      default: ;
    endcase
  end

  odrl_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .go      (mul_go),
    .mcand   (op_a),
    .mplier  (op_b),
    .done    (mul_done),
    .prod_hi (mul_hi),
    .prod_lo (mul_lo)
  );

  // log ring access
  always_comb begin
    ring_req.wr = (state == S_DONE) && log_hit;
    ring_req.rd = accept && (s_tuser == MODE_READ);
  end

  odrl_log_ring #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .req      (ring_req),
    .wr_byte  (lb_now),
    .rd_index (read_index),
    .rd_data  (rd_data),
    .fill     (fill)
  );

  // output register
  assign out_free  = !m_tvalid || m_tready;
  assign load_meas = (state == S_EMIT) && out_free;
  assign load_rd   = (state == S_READ) && out_free;

  always_comb begin
    if (state == S_READ) begin
      out_word = {fill, rd_data, BYTE_W'(0), 1'b0, pump_state, DENS_W'(0)};
    end else begin
      out_word = {fill, BYTE_W'(0), lb_r, logged_r, pump_state, dens};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_meas || load_rd) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_meas || load_rd) begin
      m_tdata <= OUT_TW'(out_word);
      m_tuser <= load_rd;
    end
  end

  `ODRL_ASSERT(a_mul_done_waited, clk, rst, mul_done |-> (state == S_REFWIN || state == S_SQUARE || state == S_LN || state == S_SLOPE), "multiplier finished with no one waiting")
  `ODRL_ASSERT(a_norm_nonzero, clk, rst, (state == S_NORM) |-> (m_val != '0), "normalizing a zero operand")
  `ODRL_ASSERT(a_round_range, clk, rst, (state == S_SQUARE) |-> (round < ROUND_W'(ROUNDS)), "squaring round out of range")
  `ODRL_ASSERT(a_window_cleared, clk, rst, (state == S_DONE) |-> (sample_count == '0 && sample_sum == '0), "window not cleared at measurement")
  `ODRL_ASSERT_ALWAYS(a_ready_idle, clk, s_tready |-> !mul_go, "input ready while multiplier started")

endmodule

FILE: hw/rtl/odrl_serial_mul.sv
// ----------------------------------------------------------------------------
// odrl_serial_mul
// 32x32 unsigned multiplier, one 4-bit digit of the multiplier per cycle.
// ----------------------------------------------------------------------------
module odrl_serial_mul (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [odrl_pkg::MUL_W-1:0] mcand,
  input  logic [odrl_pkg::MUL_W-1:0] mplier,
  output logic                     done,
  output logic [odrl_pkg::MUL_W-1:0] prod_hi,
  output logic [odrl_pkg::MUL_W-1:0] prod_lo
);
  import odrl_pkg::*;

  logic [MUL_W-1:0]         mc;
  logic [MUL_W-1:0]         mp;
  logic [MUL_CNT_W-1:0]     cnt;
  logic                     busy;
  logic [MUL_W+DIGIT_W-1:0] partial;
  logic [MUL_W+DIGIT_W-1:0] sum;

  // one digit of partial product added to the running upper half
  always_comb begin
    partial = mc * mp[DIGIT_W-1:0];
    sum     = partial + (MUL_W+DIGIT_W)'(prod_hi);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == MUL_CNT_W'(MUL_DIGITS - 1));
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_DIGITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath: low digits shift out into the lower half
  always_ff @(posedge clk) begin
    if (go) begin
      mc      <= mcand;
      mp      <= mplier;
      prod_hi <= '0;
      prod_lo <= '0;
    end else if (busy) begin
      mp      <= mp >> DIGIT_W;
      prod_hi <= sum[MUL_W+DIGIT_W-1:DIGIT_W];
      prod_lo <= {sum[DIGIT_W-1:0], prod_lo[MUL_W-1:DIGIT_W]};
    end
  end

endmodule

FILE: hw/rtl/odrl_log_ring.sv
// ----------------------------------------------------------------------------
// odrl_log_ring
// Byte log held as a ring; oldest entry is overwritten once full.
// ----------------------------------------------------------------------------
`include "optical_density_regulator_logger_assert.svh"

module odrl_log_ring #(
  parameter int LOG_DEPTH = 512
) (
  input  logic                             clk,
  input  logic                             rst,
  input  odrl_pkg::odrl_ring_req_t         req,
  input  logic [odrl_pkg::BYTE_W-1:0]      wr_byte,
  input  logic [$clog2(LOG_DEPTH)-1:0]     rd_index,
  output logic [odrl_pkg::BYTE_W-1:0]      rd_data,
  output logic [$clog2(LOG_DEPTH+1)-1:0]   fill
);
  import odrl_pkg::*;

  localparam int AW     = $clog2(LOG_DEPTH);
  localparam int FILL_W = $clog2(LOG_DEPTH + 1);

  logic [BYTE_W-1:0] mem [LOG_DEPTH];
  logic [AW-1:0]     head;
  logic              full;
  logic              rd_hit;
  logic              hit_q;
  logic [BYTE_W-1:0] rd_q;
  logic [AW:0]       rd_sum;
  logic [AW:0]       wr_sum;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     head_inc;

  // addresses, wrapped by one compare and subtract
  always_comb begin
    full   = (fill == FILL_W'(LOG_DEPTH));
    rd_hit = (FILL_W'(rd_index) < fill);
    rd_sum = {1'b0, head} + {1'b0, rd_index};
    wr_sum = {1'b0, head} + (AW+1)'(fill);
    if (rd_sum >= (AW+1)'(LOG_DEPTH)) begin
      rd_addr = AW'(rd_sum - (AW+1)'(LOG_DEPTH));
    end else begin
      rd_addr = AW'(rd_sum);
    end
    if (full) begin
      wr_addr = head;
    end else if (wr_sum >= (AW+1)'(LOG_DEPTH)) begin
      wr_addr = AW'(wr_sum - (AW+1)'(LOG_DEPTH));
    end else begin
      wr_addr = AW'(wr_sum);
    end
    if (head == AW'(LOG_DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head + 1'b1;
    end
  end

  // fill count and head pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (req.wr) begin
      if (full) begin
        head <= head_inc;
      end else begin
        fill <= fill + 1'b1;
      end
    end
  end

  // storage, registered read
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[wr_addr] <= wr_byte;
    end
    if (req.rd) begin
      rd_q  <= mem[rd_addr];
      hit_q <= rd_hit;
    end
  end

  // entries beyond the fill read as zero
  assign rd_data = hit_q ? rd_q : '0;

  `ODRL_ASSERT(a_fill_bound, clk, rst, fill <= FILL_W'(LOG_DEPTH), "log fill beyond depth")
  `ODRL_ASSERT(a_head_when_full, clk, rst, (head != '0) |-> full, "head moved before log full")
  `ODRL_ASSERT(a_fill_grows, clk, rst, (req.wr && !full) |=> (fill == $past(fill) + 1'b1), "fill did not grow on append")

endmodule
